### hdl/assert_macros.svh
// Assertion macros used by the RTL of the hashed LFSR random block.
// Depends on nothing; each macro takes the clock by name, and LHRR_ASSERT also the active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked assertion, disabled while reset is asserted.
`define LHRR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed in lfsr_hashed_random_range");

// Checked assertion that also holds during reset.
`define LHRR_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed in lfsr_hashed_random_range");

`endif

### hdl/lhrr_pkg.sv
// Package for the hashed LFSR random block: field widths, hash constants,
// state codes and the LFSR step and mix functions. Depends on nothing.
package lhrr_pkg;

    localparam int unsigned WordW  = 32;
    localparam int unsigned ValueW = 31;
    localparam int unsigned CntW   = 5;

    localparam logic [WordW-1:0]  LfsrTaps = 32'h4800_0000;
    localparam logic [WordW-1:0]  HashC1   = 32'd1376312589;
    localparam logic [WordW-1:0]  HashC2   = 32'd789221;
    localparam logic [WordW-1:0]  HashC3   = 32'd15731;
    localparam logic [WordW-1:0]  PreMul   = 32'd71;
    localparam logic [WordW-1:0]  SeedRst  = 32'd1;
    localparam logic [CntW-1:0]   DivLast  = CntW'(ValueW - 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL71 = 4'd1;
    localparam logic [3:0] S_MIX1  = 4'd2;
    localparam logic [3:0] S_SQ    = 4'd3;
    localparam logic [3:0] S_C3    = 4'd4;
    localparam logic [3:0] S_C1    = 4'd5;
    localparam logic [3:0] S_ADD   = 4'd6;
    localparam logic [3:0] S_MIX2  = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;

    typedef logic [WordW-1:0] t_word;

    // Galois step: shift right, fold the taps in when the low bit falls out.
    function automatic t_word lfsr_step(input t_word w);
        t_word r;
        r = w >> 1;
        if (w[0]) begin
            r = r ^ LfsrTaps;
        end
        return r;
    endfunction

    // Shift-xor mix with an arithmetic shift by 21, all modulo 2^32.
    function automatic t_word mix(input t_word v);
        t_word sh;
        sh = t_word'($signed(v) >>> 21);
        return ((v << 13) ^ v) - sh;
    endfunction

endpackage

### hdl/lfsr_hashed_random_range_top.sv
// Top level of the hashed LFSR random block: sequencer, shared multiply-add
// unit and restoring divider. Depends on lhrr_pkg and assert_macros.svh.
//
// Usage:
// The input channel carries one request per beat: i_operation selects the
// raw 31-bit Q0.31 fraction (0) or an integer below i_range (1). The output
// channel returns exactly one o_value beat per request. Both channels use
// valid and stall; the receiving side drives stall.
// The seed register is written through its own valid/ready port, which is
// always ready; write it only while no request is in progress.
// A request passes from acceptance to the output register through the
// states MUL71, MIX1, SQ, C3, C1, ADD and MIX2 (the shared 32x32
// multiply-add unit and mix logic) and, in integer mode, the 31 one-bit
// steps of the restoring divider. In integer mode a nonpositive range
// returns 0 through the FIN state without stepping the LFSR. One request
// is in flight at a time; o_in_stall is high while it is being worked
// on, so a new request is taken only once the sequencer is idle again.
// Reset sets the seed to 1 and clears the generator word, which is loaded
// from the seed on the next request that needs a number.
// When the receiver stalls, the finished result waits in the output
// register; the next request can still be taken, and its result waits in the
// sequencer until the output register is free.
`include "assert_macros.svh"

module lfsr_hashed_random_range_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_operation,
    input  logic signed [31:0]          i_range,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [lhrr_pkg::ValueW-1:0] o_value,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [lhrr_pkg::WordW-1:0]  i_cfg_seed
);

    logic [3:0]                  r_state, n_state;
    lhrr_pkg::t_word             r_seed;
    lhrr_pkg::t_word             r_lfsr;
    lhrr_pkg::t_word             r_acc, n_acc;
    lhrr_pkg::t_word             r_x;
    logic [lhrr_pkg::ValueW-1:0] r_rem;
    logic [lhrr_pkg::ValueW-1:0] r_rng;
    logic                        r_op;
    logic [lhrr_pkg::CntW-1:0]   r_cnt;
    logic                        r_out_valid;
    logic [lhrr_pkg::ValueW-1:0] r_value;

    logic            in_acc;
    logic            rng_bad;
    logic            out_free;
    lhrr_pkg::t_word w_load;
    lhrr_pkg::t_word w_step;
    lhrr_pkg::t_word w_mix;
    lhrr_pkg::t_word mul_a, mul_b, mul_c, mul_y;
    logic [lhrr_pkg::WordW-1:0]  div_trial;
    logic [lhrr_pkg::WordW-1:0]  div_diff;
    logic [lhrr_pkg::ValueW-1:0] div_rem;

    assign o_in_stall  = (r_state != lhrr_pkg::S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign rng_bad     = i_operation && (i_range[31] || (i_range == 32'sd0));
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;
    assign o_cfg_ready = 1'b1;

    assign w_load = (r_lfsr == '0) ? r_seed : r_lfsr;
    assign w_step = lhrr_pkg::lfsr_step(w_load);
    assign w_mix  = lhrr_pkg::mix(r_acc);

    // Shared multiply-add unit, low 32 bits.
    always_comb begin
        case (r_state)
            lhrr_pkg::S_MUL71: begin
                mul_a = r_acc; mul_b = lhrr_pkg::PreMul; mul_c = '0;
            end
            lhrr_pkg::S_SQ: begin
                mul_a = r_x; mul_b = r_x; mul_c = '0;
            end
            lhrr_pkg::S_C3: begin
                mul_a = r_acc; mul_b = lhrr_pkg::HashC3; mul_c = lhrr_pkg::HashC2;
            end
            lhrr_pkg::S_C1: begin
                mul_a = r_x; mul_b = r_acc; mul_c = lhrr_pkg::HashC1;
            end
            default: begin
                mul_a = '0; mul_b = '0; mul_c = '0;
            end
        endcase
        mul_y = lhrr_pkg::t_word'(mul_a * mul_b) + mul_c;
    end

    // One restoring division step; the remainder stays below the range.
    assign div_trial = {r_rem, r_acc[lhrr_pkg::ValueW-1]};
    assign div_diff  = div_trial - {1'b0, r_rng};
    assign div_rem   = div_diff[lhrr_pkg::WordW-1] ? div_trial[lhrr_pkg::ValueW-1:0]
                                                   : div_diff[lhrr_pkg::ValueW-1:0];

    always_comb begin
        n_state = r_state;
        n_acc   = r_acc;
        case (r_state)
            lhrr_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (rng_bad) begin
                        n_acc   = '0;
                        n_state = lhrr_pkg::S_FIN;
                    end else begin
                        n_acc   = w_step;
                        n_state = lhrr_pkg::S_MUL71;
                    end
                end
            end
            lhrr_pkg::S_MUL71: begin
                n_acc   = mul_y;
                n_state = lhrr_pkg::S_MIX1;
            end
            lhrr_pkg::S_MIX1: begin
                n_state = lhrr_pkg::S_SQ;
            end
            lhrr_pkg::S_SQ: begin
                n_acc   = mul_y;
                n_state = lhrr_pkg::S_C3;
            end
            lhrr_pkg::S_C3: begin
                n_acc   = mul_y;
                n_state = lhrr_pkg::S_C1;
            end
            lhrr_pkg::S_C1: begin
                n_acc   = mul_y;
                n_state = lhrr_pkg::S_ADD;
            end
            lhrr_pkg::S_ADD: begin
                n_acc   = {1'b0, r_acc[lhrr_pkg::ValueW-1:0]} + r_x;
                n_state = lhrr_pkg::S_MIX2;
            end
            lhrr_pkg::S_MIX2: begin
                n_acc   = {1'b0, w_mix[lhrr_pkg::ValueW-1:0]};
                n_state = r_op ? lhrr_pkg::S_DIV : lhrr_pkg::S_FIN;
            end
            lhrr_pkg::S_DIV: begin
                if (r_cnt == lhrr_pkg::DivLast) begin
                    n_acc   = {1'b0, div_rem};
                    n_state = lhrr_pkg::S_FIN;
                end else begin
                    n_acc = r_acc << 1;
                end
            end
            lhrr_pkg::S_FIN: begin
                if (out_free) begin
                    n_state = lhrr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lhrr_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lhrr_pkg::S_IDLE;
            r_seed      <= lhrr_pkg::SeedRst;
            r_lfsr      <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_seed <= i_cfg_seed;
            end
            if (in_acc && !rng_bad) begin
                r_lfsr <= w_step;
            end
            if (r_state == lhrr_pkg::S_DIV) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
            if (r_state == lhrr_pkg::S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (in_acc) begin
            r_op  <= i_operation;
            r_rng <= i_range[lhrr_pkg::ValueW-1:0];
        end
        if (r_state == lhrr_pkg::S_MIX1) begin
            r_x <= w_mix;
        end
        if (r_state == lhrr_pkg::S_MIX2) begin
            r_rem <= '0;
        end else if (r_state == lhrr_pkg::S_DIV) begin
            r_rem <= div_rem;
        end
        if (r_state == lhrr_pkg::S_FIN && out_free) begin
            r_value <= r_acc[lhrr_pkg::ValueW-1:0];
        end
    end

    `LHRR_ASSERT(a_int_below_range, i_clk, i_rst_n,
        (r_state == lhrr_pkg::S_FIN && out_free && r_op && r_rng != '0)
            |=> (o_value < $past(r_rng)))
    `LHRR_ASSERT(a_lfsr_nonzero, i_clk, i_rst_n,
        (in_acc && !rng_bad && w_load != '0 && !w_load[lhrr_pkg::WordW-1]) |=> (r_lfsr != '0))
    `LHRR_ASSERT(a_div_count, i_clk, i_rst_n,
        (r_state == lhrr_pkg::S_DIV) |-> (r_cnt <= lhrr_pkg::DivLast))
    `LHRR_ASSERT(a_fin_holds, i_clk, i_rst_n,
        (r_state == lhrr_pkg::S_FIN && !out_free) |=> (r_state == lhrr_pkg::S_FIN && $stable(r_acc)))

endmodule

### tb/lfsr_hashed_random_range_top_test.sv
// Self-checking testbench for lfsr_hashed_random_range_top: predicts every value beat
// from its own generator model and runs directed and random phases under back-pressure.
// Depends on lhrr_pkg and the RTL of the block.
module lfsr_hashed_random_range_top_test;

    localparam int CLK_PERIOD = 8;
    localparam int TIMEOUT    = 4_000_000;
    localparam int LONG_HOLD  = 200;
    localparam int HOLD_AFTER = 80;

    localparam logic OP_FRACTION = 1'b0;
    localparam logic OP_RANGE    = 1'b1;

    localparam logic [31:0] GALOIS_TAPS = 32'h4800_0000;
    localparam logic [31:0] HASH_ADD    = 32'd1376312589;
    localparam logic [31:0] HASH_LIN    = 32'd789221;
    localparam logic [31:0] HASH_SQR    = 32'd15731;
    localparam logic [31:0] SCRAMBLE    = 32'd71;
    localparam logic [31:0] LOW31       = 32'h7FFF_FFFF;

    typedef struct packed {
        logic               op;
        logic signed [31:0] rng;
    } t_request;

    logic                               i_clk       = 1'b0;
    logic                               i_rst_n     = 1'b0;
    logic                               i_in_valid  = 1'b0;
    logic                               o_in_stall;
    logic                               i_operation = 1'b0;
    logic signed [31:0]                 i_range     = '0;
    logic                               o_out_valid;
    logic                               i_out_stall = 1'b0;
    logic [lhrr_pkg::ValueW-1:0]        o_value;
    logic                               i_cfg_valid = 1'b0;
    logic                               o_cfg_ready;
    logic [lhrr_pkg::WordW-1:0]         i_cfg_seed  = '0;

    t_request                    pending_reqs[$];
    logic [lhrr_pkg::ValueW-1:0] expected_values[$];
    t_request                    cur_req;
    logic [lhrr_pkg::ValueW-1:0] want;
    logic [31:0]                 seed_reg = 32'd1;
    logic [31:0]                 gen_word = 32'd0;
    logic                        offering;
    logic                        long_hold_done = 1'b0;

    int idle_pct       = 20;
    int gap_left       = 0;
    int stall_left     = 0;
    int hold_left      = 0;
    int accepted_count = 0;
    int range_count    = 0;
    int nonpos_count   = 0;
    int results_seen   = 0;
    int seed_writes    = 0;
    int mismatches     = 0;

    lfsr_hashed_random_range_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_operation (i_operation),
        .i_range     (i_range),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_value     (o_value),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_seed  (i_cfg_seed)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic logic [31:0] scramble_word(logic [31:0] v);
        logic [31:0] sign_shifted;
        sign_shifted = {{21{v[31]}}, v[31:21]};
        return ((v << 13) ^ v) - sign_shifted;
    endfunction

    function automatic logic [31:0] hash_word(logic [31:0] s);
        logic [31:0] x;
        logic [31:0] r;
        x = scramble_word(s);
        r = (x * (x * x * HASH_SQR + HASH_LIN) + HASH_ADD) & LOW31;
        r = r + x;
        return scramble_word(r);
    endfunction

    // Advances the generator copy exactly as the block does for one request.
    function automatic logic [lhrr_pkg::ValueW-1:0] predict_value(logic op,
                                                                  logic signed [31:0] rng);
        logic [31:0] h;
        if (op == OP_RANGE && rng <= 0) begin
            return '0;
        end
        if (gen_word == 32'd0) begin
            gen_word = seed_reg;
        end
        gen_word = {1'b0, gen_word[31:1]} ^ (gen_word[0] ? GALOIS_TAPS : 32'd0);
        h = hash_word(gen_word * SCRAMBLE) & LOW31;
        if (op == OP_RANGE) begin
            h = h % $unsigned(rng);
        end
        return h[lhrr_pkg::ValueW-1:0];
    endfunction

    function automatic t_request random_request();
        t_request r;
        r.op = ($urandom_range(2) != 0) ? OP_RANGE : OP_FRACTION;
        case ($urandom_range(7))
            0: begin
                r.rng = $urandom() | 32'h8000_0000;
            end
            1: begin
                r.rng = $urandom_range(16, 1);
            end
            2: begin
                r.rng = 32'h7FFF_FFFF - $urandom_range(3);
            end
            3: begin
                r.rng = 32'h1 << $urandom_range(30);
            end
            4: begin
                r.rng = '0;
            end
            7: begin
                r.rng = $urandom();
            end
            default: begin
                r.rng = $urandom() & LOW31;
            end
        endcase
        return r;
    endfunction

    task automatic queue_req(input logic op, input logic [31:0] rng);
        t_request r;
        r.op  = op;
        r.rng = rng;
        pending_reqs.push_back(r);
    endtask

    task automatic drain(input int settle);
        @(negedge i_clk);
        while (pending_reqs.size() != 0 || i_in_valid || expected_values.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_seed(input logic [31:0] seed);
        drain(8);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_seed  <= seed;
        do @(posedge i_clk); while (!o_cfg_ready);
        seed_reg = seed;
        seed_writes++;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int count, input int pct);
        @(negedge i_clk);
        idle_pct = pct;
        repeat (count) pending_reqs.push_back(random_request());
    endtask

    // Request driver: valid is held while the block stalls, else depends on the queue and the gap counter.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            offering = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                expected_values.push_back(predict_value(cur_req.op, cur_req.rng));
                accepted_count++;
                if (cur_req.op == OP_RANGE) begin
                    range_count++;
                    if (cur_req.rng <= 0) begin
                        nonpos_count++;
                    end
                end
                offering = 1'b0;
            end
            if (!offering) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_reqs.size() != 0) begin
                    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
                        gap_left = $urandom_range(10);
                    end else begin
                        cur_req = pending_reqs.pop_front();
                        i_operation <= cur_req.op;
                        i_range     <= cur_req.rng;
                        offering = 1'b1;
                    end
                end
            end
            i_in_valid <= offering;
        end
    end

    // Output back-pressure, including one long hold so the block fills up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (!long_hold_done && accepted_count >= HOLD_AFTER) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            stall_left = $urandom_range(10);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Each accepted output beat is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_values.size() == 0) begin
                $error("value: no beat expected, got %h", o_value);
                mismatches++;
            end else begin
                want = expected_values.pop_front();
                results_seen++;
                if (o_value !== want) begin
                    $error("value: expected %h, got %h", want, o_value);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A zero seed keeps the generator word at zero, so every draw hashes zero.
        write_seed(32'h0000_0000);
        @(negedge i_clk);
        queue_req(OP_FRACTION, 32'h0000_0000);
        queue_req(OP_RANGE, 32'hFFFF_FFFF);
        queue_req(OP_FRACTION, 32'h8000_0000);
        queue_req(OP_RANGE, 32'h7FFF_FFFF);
        queue_req(OP_RANGE, 32'h0000_0001);

        write_seed(32'hFFFF_FFFF);
        @(negedge i_clk);
        queue_req(OP_RANGE, 32'h0000_0000);
        queue_req(OP_RANGE, 32'h8000_0000);
        queue_req(OP_FRACTION, 32'hFFFF_FFFF);
        queue_req(OP_FRACTION, 32'h0000_0000);
        queue_req(OP_RANGE, 32'h0000_0001);
        queue_req(OP_RANGE, 32'h0000_0002);
        queue_req(OP_RANGE, 32'h0000_0003);
        queue_req(OP_RANGE, 32'h7FFF_FFFF);
        queue_req(OP_RANGE, 32'h4000_0000);
        queue_req(OP_RANGE, 32'h0000_FFFF);
        queue_req(OP_RANGE, 32'hFFFF_FFFF);
        queue_req(OP_RANGE, 32'h8000_0001);
        queue_req(OP_FRACTION, 32'h5555_5555);
        queue_req(OP_RANGE, 32'h2AAA_AAAA);

        write_seed($urandom());
        run_random(150, 25);
        write_seed(32'h0000_0001);
        run_random(150, 0);
        write_seed($urandom());
        run_random(150, 50);
        write_seed(32'h8000_0000);
        run_random(150, 0);

        drain(50);
        $display("Checked %0d value beats from %0d requests: %0d in range mode,", results_seen,
                 accepted_count, range_count);
        $display("%0d with a nonpositive range, across %0d seed writes.", nonpos_count,
                 seed_writes);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT);
        $display("Run timed out with %0d beats still expected.", expected_values.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
